/* hdl/systematic_resampler_macros.svh */
// assertion macros for the systematic resampler
// used by the top level only, no other dependencies
`ifndef SYSTEMATIC_RESAMPLER_MACROS_SVH
`define SYSTEMATIC_RESAMPLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler check failed");

// next-cycle implication, checked outside reset
`define SR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler check failed");

`endif

/* hdl/sysres_pkg.sv */
// shared types and constants of the systematic resampler
// no dependencies
package sysres_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_DRAW  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PARTICLE_COUNT = 2'd0;
  localparam logic [1:0] CFG_STEP_FRACTION  = 2'd1;
  localparam logic [1:0] CFG_FRESH_SLOTS    = 2'd2;

  // configuration reset values
  localparam logic [10:0] PARTICLE_COUNT_RST = 11'd1024;
  localparam logic [31:0] STEP_FRACTION_RST  = 32'd4194304;
  localparam logic [10:0] FRESH_SLOTS_RST    = 11'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] weight;
    logic [31:0] offset;
    logic        landmark_seen;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] slot;
    logic [9:0] source_index;
    logic       fresh;
    logic       last;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;
    logic start;
    logic sum0;
    logic step;
    logic emit;
  } sysres_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pass_done;
    logic walk_more;
    logic out_free;
  } sysres_sts_t;

endpackage

/* hdl/sysres_ctrl.sv */
// control state machine of the systematic resampler
// depends on sysres_pkg
module sysres_ctrl import sysres_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  kind_i,
  output logic        in_ready_o,
  input  sysres_sts_t sts_i,
  output sysres_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM0 = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_i)
            KIND_LOAD: begin
              cmd_o.load_wr = 1'b1;
            end
            KIND_START: begin
              cmd_o.start = 1'b1;
              state_d     = ST_SUM0;
            end
            KIND_DRAW: begin
              if (!sts_i.pass_done) begin
                state_d = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SUM0: begin
        cmd_o.sum0 = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_WALK: begin
        if (sts_i.walk_more) begin
          cmd_o.step = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/sysres_dp.sv */
// datapath of the systematic resampler: weight memory, walk registers,
// configuration registers and output register; depends on sysres_pkg
module sysres_dp import sysres_pkg::*; #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  in_beat_t    in_data_i,
  input  sysres_cmd_t cmd_i,
  output sysres_sts_t sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam logic [AW:0] MAX_L = (AW + 1)'(MAX_PARTICLES);
  localparam logic [33:0] SUM_MAX = {34{1'b1}};

  logic [31:0] mem [MAX_PARTICLES];
  logic [31:0] rdata_q;
  logic [AW-1:0] rd_addr;

  logic [10:0] pcount_q;
  logic [31:0] step_q;
  logic [10:0] fslots_q;

  logic [AW:0]   lp_q;
  logic [AW-1:0] walk_q;
  logic [33:0]   cum_q;
  logic [33:0]   target_q;
  logic [10:0]   slot_q;
  logic          inject_q;
  logic          out_valid_q;
  out_beat_t     out_q;

  logic [10:0] n_eff;
  logic [10:0] f_eff;
  logic        fresh;
  logic [34:0] cum_sum;
  logic [34:0] tgt_sum;
  logic [33:0] cum_next;
  logic [33:0] tgt_next;
  logic [31:0] walk_ext;
  logic [31:0] walk_nxt_ext;
  logic        load_ok;

  // effective particle count and fresh count
  always_comb begin
    if (pcount_q == 11'd0) begin
      n_eff = 11'd1;
    end else if (32'(pcount_q) > 32'(MAX_PARTICLES)) begin
      n_eff = 11'(MAX_PARTICLES);
    end else begin
      n_eff = pcount_q;
    end
    f_eff = (fslots_q > n_eff) ? n_eff : fslots_q;
  end

  assign fresh        = inject_q && (slot_q >= (n_eff - f_eff));
  assign walk_ext     = 32'(walk_q);
  assign walk_nxt_ext = walk_ext + 32'd1;

  // saturating 34-bit sums
  assign cum_sum  = {1'b0, cum_q} + {3'b000, rdata_q};
  assign cum_next = cum_sum[34] ? SUM_MAX : cum_sum[33:0];
  assign tgt_sum  = {1'b0, target_q} + {3'b000, step_q};
  assign tgt_next = tgt_sum[34] ? SUM_MAX : tgt_sum[33:0];

  assign sts_o.pass_done = (slot_q >= n_eff);
  assign sts_o.walk_more = !fresh && (target_q > cum_q) && (walk_nxt_ext < 32'(n_eff));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign load_ok = (lp_q < MAX_L);

  // read port runs one weight ahead of the walk index
  always_comb begin
    if (cmd_i.start) begin
      rd_addr = '0;
    end else if (cmd_i.step) begin
      rd_addr = walk_q + AW'(1) + AW'(1);
    end else begin
      rd_addr = walk_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && load_ok) begin
      mem[lp_q[AW-1:0]] <= in_data_i.weight;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= PARTICLE_COUNT_RST;
      step_q   <= STEP_FRACTION_RST;
      fslots_q <= FRESH_SLOTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PARTICLE_COUNT: pcount_q <= cfg_data_i[10:0];
        CFG_STEP_FRACTION:  step_q   <= cfg_data_i;
        CFG_FRESH_SLOTS:    fslots_q <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q        <= '0;
      walk_q      <= '0;
      cum_q       <= '0;
      target_q    <= '0;
      slot_q      <= '0;
      inject_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_wr && load_ok) begin
        lp_q <= lp_q + (AW + 1)'(1);
      end
      if (cmd_i.start) begin
        target_q <= {2'b00, in_data_i.offset};
        inject_q <= in_data_i.landmark_seen;
        walk_q   <= '0;
        slot_q   <= '0;
        lp_q     <= '0;
      end
      if (cmd_i.sum0) begin
        cum_q <= {2'b00, rdata_q};
      end
      if (cmd_i.step) begin
        walk_q <= walk_q + AW'(1);
        cum_q  <= cum_next;
      end
      if (cmd_i.emit) begin
        target_q    <= tgt_next;
        slot_q      <= slot_q + 11'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.slot         <= slot_q[9:0];
      out_q.source_index <= fresh ? 10'd0 : walk_ext[9:0];
      out_q.fresh        <= fresh;
      out_q.last         <= ((slot_q + 11'd1) == n_eff);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/systematic_resampler.sv */
// top level of the systematic resampler particle-filter block
// depends on sysres_pkg, sysres_ctrl, sysres_dp and systematic_resampler_macros.svh

// systematic resampler: load normalized Q0.32 weights one beat each (kind 0),
// then a start beat (kind 1) sets the random offset and the landmark flag, and
// each draw beat (kind 2) yields one result beat with the chosen source index.
// a load or an unused-kind beat is handled in the idle state alone, a start
// beat adds the memory read of weight 0, and a draw beat goes to the walk
// state, which steps one weight per cycle and then emits the result; a whole
// pass of n draws walks at most n-1 weights. the walk speed is set by the
// single read port of the weight memory, which runs one weight ahead of the
// walk index, and by the 34-bit saturating add and compare in the walk loop.
// a result waits in the output register while later loads and starts are
// taken; a draw whose result is ready holds in the walk state until the
// output register frees up. draws after n slots of a pass give no result.
module systematic_resampler import sysres_pkg::*; #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o
);

`include "systematic_resampler_macros.svh"

  sysres_cmd_t cmd;
  sysres_sts_t sts;

  // sequencing of load, start and draw beats
  sysres_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_data_i.kind),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // weight memory, walk state and result register
  sysres_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a result is only written into a free or draining output register
  `SR_ASSERT_NOW(a_emit_free, clk_i, rst_ni, cmd.emit, (!out_valid_o || out_ready_i))
  // a start beat is followed by the weight 0 fetch cycle
  `SR_ASSERT_NEXT(a_start_busy, clk_i, rst_ni,
    (in_valid_i && in_ready_o && in_data_i.kind == KIND_START), !in_ready_o)
  // a draw past the end of the pass is dropped without leaving idle
  `SR_ASSERT_NEXT(a_done_drop, clk_i, rst_ni,
    (in_valid_i && in_ready_o && in_data_i.kind == KIND_DRAW && sts.pass_done),
    in_ready_o)
  // a walk step never coincides with a result
  `SR_ASSERT_NOW(a_step_emit, clk_i, rst_ni, cmd.step, !cmd.emit)

endmodule

/* tb/sv/tb_systematic_resampler.sv */
// self-checking testbench for the systematic resampler top level
// depends on sysres_pkg and systematic_resampler; predicts every result beat in place
`timescale 1ns / 100ps

module tb_systematic_resampler;
  import sysres_pkg::*;

  localparam int          MAX_N       = 1024;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [33:0] SUM_CEIL    = 34'h3_FFFF_FFFF;
  // cycles a load, a start or a draw with no result may still be busy
  localparam int          DRAIN_CYCLES = 16;
  localparam int          HOLD_CYCLES  = 400;
  // full-scale weights loaded for a large pass; the running sum saturates
  // after five of them, so the walk never leaves this prefix
  localparam int          BIG_PREFIX   = 8;
  // beats of a used kind a random phase must queue before it is closed
  localparam int          PHASE_BEATS  = 60;

  // clock, reset and block ports
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;

  // stimulus and expected results
  in_beat_t  pending_beats[$];
  out_beat_t expected_slots[$];

  // idle control
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  logic hold_req     = 1'b0;
  int   rx_hold_left = 0;

  // run bookkeeping
  int beats_taken      = 0;
  int slots_checked    = 0;
  int fresh_seen       = 0;
  int ends_seen        = 0;
  int mismatches       = 0;
  int settings_written = 0;

  // generator view of the weight store: write pointer and written prefix
  int gen_ptr     = 0;
  int gen_hi      = 0;
  int phase_items = 0;

  // predictor state, mirrors the block
  logic [31:0] wt_mem [MAX_N];
  logic [10:0] ld_ptr     = '0;
  logic [9:0]  walk_idx   = '0;
  logic [33:0] run_sum    = '0;
  logic [33:0] u_target   = '0;
  logic [10:0] slots_done = '0;
  logic        inject_on  = 1'b0;
  // register shadows
  logic [10:0] count_reg  = PARTICLE_COUNT_RST;
  logic [31:0] step_reg   = STEP_FRACTION_RST;
  logic [10:0] fresh_reg  = FRESH_SLOTS_RST;

  systematic_resampler u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random single bit
  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  // saturating add on the 34-bit walk sums
  function automatic logic [33:0] add_sat34(input logic [33:0] a, input logic [33:0] b);
    logic [34:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SUM_CEIL}) ? SUM_CEIL : s[33:0];
  endfunction

  // particles in use: zero acts as one, capped at the store depth
  function automatic int active_count();
    int n;
    n = int'(count_reg);
    if (n == 0) n = 1;
    if (n > MAX_N) n = MAX_N;
    return n;
  endfunction

  // advance the predictor by one accepted beat, queue the slot it fills
  task automatic predict_resample(input in_beat_t b);
    int        n;
    int        f;
    int        m;
    logic      fresh;
    out_beat_t r;
    case (b.kind)
      KIND_LOAD: begin
        // loads past the end of the store are dropped
        if (ld_ptr < MAX_N) begin
          wt_mem[ld_ptr[9:0]] = b.weight;
          ld_ptr = ld_ptr + 1'b1;
        end
      end
      KIND_START: begin
        u_target   = {2'b00, b.offset};
        inject_on  = b.landmark_seen;
        walk_idx   = '0;
        run_sum    = {2'b00, wt_mem[0]};
        slots_done = '0;
        ld_ptr     = '0;
      end
      KIND_DRAW: begin
        n = active_count();
        f = (int'(fresh_reg) > n) ? n : int'(fresh_reg);
        m = int'(slots_done);
        // once n slots are filled the pass is done and draws are silent
        if (m < n) begin
          fresh = inject_on && (m >= n - f);
          r.source_index = '0;
          if (!fresh) begin
            // walk the running sum, saturating at the last particle
            while (u_target > run_sum && int'(walk_idx) + 1 < n) begin
              walk_idx = walk_idx + 1'b1;
              run_sum  = add_sat34(run_sum, {2'b00, wt_mem[walk_idx]});
            end
            r.source_index = walk_idx;
          end
          u_target   = add_sat34(u_target, {2'b00, step_reg});
          slots_done = slots_done + 1'b1;
          r.slot     = m[9:0];
          r.fresh    = fresh;
          r.last     = (m + 1 == n);
          expected_slots.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // input side: present queued beats, idle at random between them
  always @(posedge clk) begin
    logic keep;
    if (in_valid && in_ready) begin
      predict_resample(in_data);
      beats_taken++;
    end
    // an offered beat stays up unchanged until it is taken
    keep = in_valid && !in_ready;
    if (!keep) begin
      if (rst_n && pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here so the sender keeps going
  always @(posedge clk) begin
    if (hold_req) begin
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // output side: check each result beat against the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (out_valid && out_ready) begin
      if (expected_slots.size() == 0) begin
        $error("result beat with no draw pending: slot %0d source_index %0d",
               out_data.slot, out_data.source_index);
        mismatches++;
      end else begin
        want = expected_slots.pop_front();
        if (out_data.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
          mismatches++;
        end
        if (out_data.source_index !== want.source_index) begin
          $error("source_index: expected %0d, got %0d", want.source_index,
                 out_data.source_index);
          mismatches++;
        end
        if (out_data.fresh !== want.fresh) begin
          $error("fresh: expected %0d, got %0d", want.fresh, out_data.fresh);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          mismatches++;
        end
        if (want.fresh) fresh_seen++;
        if (want.last) ends_seen++;
      end
      slots_checked++;
    end
    out_ready <= rst_n && (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  // one register write, block idle; shadow follows at once
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_PARTICLE_COUNT: count_reg = val[10:0];
      CFG_STEP_FRACTION:  step_reg  = val;
      CFG_FRESH_SLOTS:    fresh_reg = val[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // queue one beat and track which store entries are written
  task automatic queue_beat(input logic [1:0] kind, input logic [31:0] w,
                            input logic [31:0] ofs, input logic lm);
    in_beat_t b;
    b.kind          = kind;
    b.weight        = w;
    b.offset        = ofs;
    b.landmark_seen = lm;
    pending_beats.push_back(b);
    if (kind == KIND_LOAD && gen_ptr < MAX_N) begin
      gen_ptr++;
      if (gen_ptr > gen_hi) gen_hi = gen_ptr;
    end else if (kind == KIND_START) begin
      gen_ptr = 0;
    end
    if (kind != KIND_UNUSED) phase_items++;
  endtask

  // weight styles: near 1/n, full range, extremes, mostly zero
  function automatic logic [31:0] pick_weight(input int wmode, input int n);
    longint base;
    longint w;
    int     sel;
    base = 64'sh1_0000_0000 / n;
    if (base > 64'shFFFF_FFFF) base = 64'shFFFF_FFFF;
    case (wmode)
      0: begin
        w = base / 2 + {32'h0, $urandom_range(base[31:0], 0)};
        if (w > 64'shFFFF_FFFF) w = 64'shFFFF_FFFF;
        return w[31:0];
      end
      1: return $urandom();
      2: begin
        sel = $urandom_range(2);
        return (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom();
      end
      default: return ($urandom_range(3) == 0) ? $urandom_range(255) : 32'h0;
    endcase
  endfunction

  // one well-formed pass with random content, now and then a broken tail
  task automatic run_pass();
    int          n;
    int          draws;
    int          wmode;
    int          sel;
    int          i;
    logic        big;
    logic [31:0] ofs;
    n     = active_count();
    big   = (n > 64);
    wmode = $urandom_range(3);
    // a large pass loads a short full-scale prefix; a small one reloads
    // unless the written prefix already covers n and we reuse it
    if (big || gen_hi < n || $urandom_range(3) != 0) begin
      if (gen_ptr != 0) queue_beat(KIND_START, $urandom(), $urandom(), coin());
      for (i = 0; i < (big ? BIG_PREFIX : n); i++) begin
        queue_beat(KIND_LOAD, big ? 32'hFFFF_FFFF : pick_weight(wmode, n), $urandom(),
                   coin());
      end
    end
    sel = $urandom_range(7);
    if (sel == 0) ofs = 32'h0;
    else if (sel == 1) ofs = 32'hFFFF_FFFF;
    else if (sel == 2 || step_reg == 0) ofs = $urandom();
    else ofs = $urandom_range(step_reg - 1, 0);
    queue_beat(KIND_START, $urandom(), ofs, coin());
    sel = $urandom_range(7);
    if (big) draws = $urandom_range(40, 8);
    else if (sel == 0) draws = $urandom_range(n - 1, 0);
    else if (sel == 1) draws = n + $urandom_range(3, 1);
    else draws = n;
    for (i = 0; i < draws; i++) begin
      queue_beat(KIND_DRAW, $urandom(), $urandom(), coin());
    end
    // noise: unused kind, a few stray loads, or one more draw
    if ($urandom_range(4) == 0) begin
      sel = $urandom_range(2);
      if (sel == 0) begin
        queue_beat(KIND_UNUSED, $urandom(), $urandom(), coin());
      end else if (sel == 1) begin
        for (i = 0; i < int'($urandom_range(3, 1)); i++) begin
          queue_beat(KIND_LOAD, $urandom(), $urandom(), coin());
        end
      end else begin
        queue_beat(KIND_DRAW, $urandom(), $urandom(), coin());
      end
    end
  endtask

  // wait for all beats taken and all results seen, then let the block drain
  task automatic settle();
    while (pending_beats.size() != 0 || in_valid || expected_slots.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          ph;
    int          sel;
    int          n;
    int          i;
    logic [31:0] junk;
    logic [31:0] stepv;
    logic [10:0] cnt;
    longint      q;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: four particles, quarter step, one fresh slot
    write_reg(CFG_PARTICLE_COUNT, 32'd4);
    write_reg(CFG_STEP_FRACTION, 32'h4000_0000);
    write_reg(CFG_FRESH_SLOTS, 32'd1);
    queue_beat(KIND_LOAD, 32'h0000_0000, $urandom(), 1'b1);
    queue_beat(KIND_LOAD, 32'hFFFF_FFFF, $urandom(), 1'b0);
    queue_beat(KIND_LOAD, 32'h4000_0000, $urandom(), 1'b1);
    queue_beat(KIND_LOAD, 32'h8000_0000, $urandom(), 1'b0);
    // draws before any start run from the reset walk state
    queue_beat(KIND_DRAW, $urandom(), $urandom(), 1'b1);
    queue_beat(KIND_DRAW, $urandom(), $urandom(), 1'b0);
    queue_beat(KIND_UNUSED, $urandom(), $urandom(), 1'b1);
    // landmark pass: last slot fresh, fifth draw past the end is silent
    queue_beat(KIND_START, $urandom(), 32'h0, 1'b1);
    for (i = 0; i < 5; i++) queue_beat(KIND_DRAW, $urandom(), $urandom(), coin());
    // offset at the top of the range
    queue_beat(KIND_START, $urandom(), 32'hFFFF_FFFF, 1'b0);
    for (i = 0; i < 4; i++) queue_beat(KIND_DRAW, $urandom(), $urandom(), coin());
    // reload weight 0 after a start, then another landmark pass
    queue_beat(KIND_LOAD, 32'hFFFF_FFFF, $urandom(), 1'b1);
    queue_beat(KIND_START, $urandom(), 32'h3FFF_FFFF, 1'b1);
    for (i = 0; i < 4; i++) queue_beat(KIND_DRAW, $urandom(), $urandom(), coin());
    settle();

    // random phases, each with its own settings and idle pattern
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 47; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 47; end
        default: begin tx_idle_pct = 14; rx_idle_pct = 14; end
      endcase
      sel = $urandom_range(9);
      if (ph == 11) cnt = 11'd2047;
      else if (sel == 0) cnt = 11'd0;
      else if (sel <= 2) cnt = sel[10:0];
      else if (sel <= 6) cnt = 11'($urandom_range(16, 3));
      else if (sel <= 8) cnt = 11'($urandom_range(64, 17));
      else cnt = 11'($urandom_range(2047, 1024));
      // upper data bits beyond the register width are junk
      junk = $urandom();
      write_reg(CFG_PARTICLE_COUNT, {junk[31:11], cnt});
      n = active_count();
      sel = $urandom_range(5);
      q = 64'sh1_0000_0000 / n;
      if (q > 64'shFFFF_FFFF) q = 64'shFFFF_FFFF;
      if (sel <= 2) stepv = q[31:0];
      else if (sel == 3) stepv = $urandom();
      else if (sel == 4) stepv = 32'h0;
      else stepv = 32'hFFFF_FFFF;
      write_reg(CFG_STEP_FRACTION, stepv);
      sel = $urandom_range(4);
      if (sel == 0) cnt = 11'd0;
      else if (sel == 1) cnt = 11'($urandom_range(n, 0));
      else if (sel == 2) cnt = n[10:0];
      else if (sel == 3) cnt = 11'd2047;
      else cnt = 11'($urandom_range(3, 0));
      junk = $urandom();
      write_reg(CFG_FRESH_SLOTS, {junk[31:11], cnt});
      // receiver goes quiet for a long stretch while beats keep coming
      if (ph == 4 || ph == 8) begin
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      phase_items = 0;
      while (phase_items < PHASE_BEATS) run_pass();
      settle();
    end

    $display("covered %0d register writes over 1 to 1024 particles, fresh slots and stalls",
             settings_written);
    $display("%0d input beats taken, %0d result beats checked, %0d fresh, %0d pass ends",
             beats_taken, slots_checked, fresh_seen, ends_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* systematic_resampler.f */
+incdir+hdl
hdl/sysres_pkg.sv
hdl/sysres_ctrl.sv
hdl/sysres_dp.sv
hdl/systematic_resampler.sv
tb/sv/tb_systematic_resampler.sv
